// ===== rtl/albf_pkg.sv =====
`default_nettype none
package albf_pkg;

    localparam logic [2:0] KIND_PART_DATA   = 3'd0;
    localparam logic [2:0] KIND_PART_END    = 3'd1;
    localparam logic [2:0] KIND_ENTRY_END   = 3'd2;
    localparam logic [2:0] KIND_ENTRY_START = 3'd3;
    localparam logic [2:0] KIND_PART_START  = 3'd4;

    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_Z       = 8'h5A;

    localparam int MIN_HEX = 8;

    localparam logic [2:0] STAGE_DONE = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  letter;
        logic [10:0] len;
        logic [31:0] poff;
    } res_t;

    typedef struct packed {
        logic        two;
        res_t        r0;
        res_t        r1;
        logic [31:0] eoff;
        logic [31:0] esize;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/albf_ram.sv =====
`default_nettype none
module albf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/albf_front.sv =====
`default_nettype none
module albf_front #(
    parameter int LINE_MAX     = 1024,
    parameter int BOUNDARY_MAX = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic [7:0]    data_byte,
    output logic               cmd_push,
    output albf_pkg::cmd_t     cmd
);

    localparam int LLW = $clog2(LINE_MAX + 1);
    localparam int HW  = $clog2(BOUNDARY_MAX + 1);
    localparam int AW  = $clog2(BOUNDARY_MAX);

    logic [31:0]    byte_off_reg, byte_off_next;
    logic [LLW-1:0] line_len_reg, line_len_next;
    logic           lhb_reg, lhb_next;
    logic [31:0]    lso_reg, lso_next;
    logic [2:0]     stage_reg, stage_next;
    logic [HW-1:0]  hex_reg, hex_next;
    logic           cv_reg, cv_next;
    logic [7:0]     cl_reg, cl_next;
    logic           mis_reg, mis_next;
    logic [HW-1:0]  elen_reg, elen_next;
    logic           in_entry_reg, in_entry_next;
    logic           in_part_reg, in_part_next;
    logic [7:0]     cur_reg, cur_next;
    logic [31:0]    pb_reg, pb_next;
    logic [31:0]    eb_reg, eb_next;

    logic           ram_we;
    logic [7:0]     ram_rdata;

    albf_ram #(.WIDTH(8), .DEPTH(BOUNDARY_MAX)) u_bnd_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (hex_reg[AW-1:0]),
        .wdata (data_byte),
        .raddr (hex_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    albf_pkg::res_t slot [2];
    logic [1:0]     n;
    logic           ovf, lhb_e, accept;
    logic [2:0]     stage_e;
    logic [HW-1:0]  hex_e;
    logic           cv_e, mis_e;
    logic [7:0]     cl_e;
    logic [31:0]    lso_e, bo1;
    logic [LLW-1:0] ll;

    always_comb
    begin
        byte_off_next = byte_off_reg;
        line_len_next = line_len_reg;
        lhb_next      = lhb_reg;
        lso_next      = lso_reg;
        stage_next    = stage_reg;
        hex_next      = hex_reg;
        cv_next       = cv_reg;
        cl_next       = cl_reg;
        mis_next      = mis_reg;
        elen_next     = elen_reg;
        in_entry_next = in_entry_reg;
        in_part_next  = in_part_reg;
        cur_next      = cur_reg;
        pb_next       = pb_reg;
        eb_next       = eb_reg;
        ram_we        = 1'b0;
        slot[0]       = '0;
        slot[1]       = '0;
        n             = 2'd0;
        accept        = 1'b0;

        ovf     = line_len_reg >= LLW'(LINE_MAX);
        stage_e = ovf ? 3'd0 : stage_reg;
        hex_e   = ovf ? '0 : hex_reg;
        cv_e    = ovf ? 1'b1 : cv_reg;
        cl_e    = ovf ? 8'd0 : cl_reg;
        mis_e   = ovf ? 1'b0 : mis_reg;
        lhb_e   = ovf ? 1'b0 : lhb_reg;
        lso_e   = ovf ? byte_off_reg : lso_reg;
        bo1     = byte_off_reg + 32'd1;
        ll      = (ovf ? '0 : line_len_reg) + LLW'(1);

        if (take)
        begin
            if (ovf && in_part_reg)
            begin
                slot[0] = '{albf_pkg::KIND_PART_DATA, cur_reg, 11'(line_len_reg), pb_reg};
                n = 2'd1;
            end

            stage_next = stage_e;
            hex_next   = hex_e;
            cv_next    = cv_e;
            cl_next    = cl_e;
            mis_next   = mis_e;
            if (cv_e)
            begin
                case (stage_e)
                    3'd0, 3'd1, 3'd4, 3'd5:
                    begin
                        if (data_byte == albf_pkg::CHAR_DASH)
                            stage_next = stage_e + 3'd1;
                        else
                            cv_next = 1'b0;
                    end
                    3'd2:
                    begin
                        if (albf_pkg::is_hex(data_byte))
                        begin
                            if (hex_e < HW'(BOUNDARY_MAX))
                            begin
                                ram_we   = !in_entry_reg;
                                hex_next = hex_e + HW'(1);
                                if (in_entry_reg && data_byte != ram_rdata)
                                    mis_next = 1'b1;
                            end
                            else
                                cv_next = 1'b0;
                        end
                        else if (data_byte == albf_pkg::CHAR_DASH
                                 && hex_e >= HW'(albf_pkg::MIN_HEX))
                            stage_next = 3'd3;
                        else
                            cv_next = 1'b0;
                    end
                    3'd3:
                    begin
                        if (data_byte >= albf_pkg::CHAR_A && data_byte <= albf_pkg::CHAR_Z)
                        begin
                            cl_next    = data_byte;
                            stage_next = 3'd4;
                        end
                        else
                            cv_next = 1'b0;
                    end
                    3'd6:
                    begin
                        if (data_byte == albf_pkg::CHAR_NEWLINE)
                            stage_next = albf_pkg::STAGE_DONE;
                        else
                            cv_next = 1'b0;
                    end
                    default: cv_next = 1'b0;
                endcase
            end

            byte_off_next = bo1;
            line_len_next = ll;
            lhb_next      = lhb_e;
            lso_next      = lso_e;

            if (data_byte == albf_pkg::CHAR_NEWLINE)
            begin
                accept = lhb_e && cv_next && stage_next == albf_pkg::STAGE_DONE
                      && (!in_entry_reg || (hex_next == elen_reg && !mis_next));
                if (accept)
                begin
                    if (in_part_reg)
                    begin
                        slot[n[0]] = '{albf_pkg::KIND_PART_END, cur_reg, 11'd0, pb_reg};
                        n = n + 2'd1;
                        in_part_next = 1'b0;
                        if (cl_next == albf_pkg::CHAR_Z)
                        begin
                            slot[n[0]] = '{albf_pkg::KIND_ENTRY_END, albf_pkg::CHAR_Z,
                                           11'd0, 32'd0};
                            n = n + 2'd1;
                            in_entry_next = 1'b0;
                        end
                    end
                    if (cl_next != albf_pkg::CHAR_Z)
                    begin
                        if (!in_entry_reg)
                        begin
                            in_entry_next = 1'b1;
                            eb_next       = lso_e;
                            elen_next     = hex_next;
                            slot[n[0]] = '{albf_pkg::KIND_ENTRY_START, cl_next, 11'd0, 32'd0};
                            n = n + 2'd1;
                        end
                        in_part_next = 1'b1;
                        cur_next     = cl_next;
                        pb_next      = bo1;
                        slot[n[0]] = '{albf_pkg::KIND_PART_START, cl_next, 11'd0, bo1};
                        n = n + 2'd1;
                    end
                end
                else if (in_part_reg)
                begin
                    slot[n[0]] = '{albf_pkg::KIND_PART_DATA, cur_reg, 11'(ll), pb_reg};
                    n = n + 2'd1;
                end
                line_len_next = '0;
                lhb_next      = 1'b1;
                lso_next      = bo1;
                stage_next    = 3'd0;
                hex_next      = '0;
                cv_next       = 1'b1;
                cl_next       = 8'd0;
                mis_next      = 1'b0;
            end
        end

        cmd_push  = take && n != 2'd0;
        cmd.two   = n == 2'd2;
        cmd.r0    = slot[0];
        cmd.r1    = slot[1];
        cmd.eoff  = eb_next;
        cmd.esize = bo1 - eb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_off_reg <= '0;
            line_len_reg <= '0;
            lhb_reg      <= 1'b1;
            lso_reg      <= '0;
            stage_reg    <= '0;
            hex_reg      <= '0;
            cv_reg       <= 1'b1;
            cl_reg       <= '0;
            mis_reg      <= 1'b0;
            elen_reg     <= '0;
            in_entry_reg <= 1'b0;
            in_part_reg  <= 1'b0;
            cur_reg      <= '0;
            pb_reg       <= '0;
            eb_reg       <= '0;
        end
        else
        begin
            byte_off_reg <= byte_off_next;
            line_len_reg <= line_len_next;
            lhb_reg      <= lhb_next;
            lso_reg      <= lso_next;
            stage_reg    <= stage_next;
            hex_reg      <= hex_next;
            cv_reg       <= cv_next;
            cl_reg       <= cl_next;
            mis_reg      <= mis_next;
            elen_reg     <= elen_next;
            in_entry_reg <= in_entry_next;
            in_part_reg  <= in_part_next;
            cur_reg      <= cur_next;
            pb_reg       <= pb_next;
            eb_reg       <= eb_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/albf_cmd_fifo.sv =====
`default_nettype none
module albf_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire albf_pkg::cmd_t wdata,
    output logic                full,
    input  wire logic           rd,
    output logic                nonempty,
    output albf_pkg::cmd_t      rdata
);

    albf_pkg::cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign rdata    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(wr && full))
        else $error("cmd fifo overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(rd && !nonempty))
        else $error("cmd fifo underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("cmd fifo count out of range");

endmodule
`default_nettype wire

// ===== rtl/albf_back.sv =====
`default_nettype none
module albf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire albf_pkg::cmd_t in_cmd,
    output logic                in_pop,
    input  wire logic           pop,
    output logic                empty,
    output logic [2:0]          event_kind,
    output logic [7:0]          part_letter,
    output logic [10:0]         chunk_length,
    output logic [31:0]         part_offset,
    output logic [31:0]         part_size,
    output logic [31:0]         entry_offset,
    output logic [31:0]         entry_size,
    output logic                last_of_run
);

    albf_pkg::cmd_t cur_reg;
    logic           valid_reg, idx_reg;
    logic [31:0]    pbc_reg, pbc_next;
    albf_pkg::res_t r;
    logic           take, load;
    logic [31:0]    sum;

    always_comb
    begin
        r    = idx_reg ? cur_reg.r1 : cur_reg.r0;
        sum  = pbc_reg + 32'(r.len);
        last_of_run = idx_reg || !cur_reg.two;
        take = pop && valid_reg;
        load = !valid_reg || (take && last_of_run);
        in_pop = load && in_valid;

        empty        = !valid_reg;
        event_kind   = r.kind;
        part_letter  = r.letter;
        chunk_length = r.len;
        part_offset  = r.poff;
        entry_offset = cur_reg.eoff;
        part_size    = 32'd0;
        entry_size   = 32'd0;
        pbc_next     = pbc_reg;
        case (r.kind)
            albf_pkg::KIND_PART_DATA:
            begin
                part_size = sum;
                pbc_next  = sum;
            end
            albf_pkg::KIND_PART_END:   part_size  = pbc_reg;
            albf_pkg::KIND_ENTRY_END:  entry_size = cur_reg.esize;
            albf_pkg::KIND_PART_START: pbc_next   = 32'd0;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_pop)
            cur_reg <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
            pbc_reg   <= '0;
        end
        else
        begin
            if (take)
                pbc_reg <= pbc_next;
            if (load)
            begin
                valid_reg <= in_valid;
                idx_reg   <= 1'b0;
            end
            else if (take)
                idx_reg <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/audit_log_boundary_framer_top.sv =====
`default_nettype none
// Log boundary framer. Takes one stream byte per cycle on push/full and gives
// framing events (entry start, part start, part data, part end, entry end) on
// empty/pop. A byte is taken every cycle as long as the two-deep command queue
// between the line classifier and the event sequencer has room; a byte that
// causes two events occupies the sequencer until both are popped, so sustained input
// rate is one byte per cycle when the result side drains one event per cycle
// and events average at most one per byte.
module audit_log_boundary_framer_top #(
    parameter int LINE_MAX     = 1024,
    parameter int BOUNDARY_MAX = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       event_kind,
    output logic [7:0]       part_letter,
    output logic [10:0]      chunk_length,
    output logic [31:0]      part_offset,
    output logic [31:0]      part_size,
    output logic [31:0]      entry_offset,
    output logic [31:0]      entry_size,
    output logic             last_of_run
);

    albf_pkg::cmd_t f_cmd, q_cmd;
    logic           f_push, q_valid, q_pop;

    albf_front #(.LINE_MAX(LINE_MAX), .BOUNDARY_MAX(BOUNDARY_MAX)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (push && !full),
        .data_byte (data_byte),
        .cmd_push  (f_push),
        .cmd       (f_cmd)
    );

    albf_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (f_push),
        .wdata    (f_cmd),
        .full     (full),
        .rd       (q_pop),
        .nonempty (q_valid),
        .rdata    (q_cmd)
    );

    albf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_cmd       (q_cmd),
        .in_pop       (q_pop),
        .pop          (pop),
        .empty        (empty),
        .event_kind   (event_kind),
        .part_letter  (part_letter),
        .chunk_length (chunk_length),
        .part_offset  (part_offset),
        .part_size    (part_size),
        .entry_offset (entry_offset),
        .entry_size   (entry_size),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire
